// ----- rtl/frfs_pkg.sv -----
// package for the frame rotate/flip/shift unit
// types, operation codes and constants; no dependencies
`default_nettype none
package frfs_pkg;

  localparam int MAX_SIDE_DEF = 64;
  localparam logic [23:0] WHITE = 24'hFFFFFF;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_READ   = 3'd1,
    OP_SHUP   = 3'd2,
    OP_SHLEFT = 3'd3,
    OP_ROT    = 3'd4,
    OP_FLIPR  = 3'd5,
    OP_FLIPC  = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_BACK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [5:0]  pixel_row;
    logic [5:0]  pixel_col;
    logic [23:0] pixel_in;
    logic [7:0]  amount;
  } in_item_t;

  typedef struct packed {
    logic [23:0] pixel_out;
    logic        read_valid;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/frame_rotate_flip_shift_unit.sv -----
// top level of the frame rotate/flip/shift unit
// depends on frfs_pkg
`default_nettype none
// Holds a square frame of 24-bit pixels in a frame memory and runs one
// command per input transaction, giving one result transaction each. A
// whole-frame command (shift, rotate, flip) makes a remap pass into a
// scratch memory, one pixel per cycle reading the source from the frame
// memory, then a copy-back pass, one pixel per cycle. The single read port
// of each memory sets the pace of these passes. No input transaction is
// taken while a command is in progress; a finished result waits in the
// output register until taken. Memories are not cleared; reading a
// never-written pixel gives undefined data.
module frame_rotate_flip_shift_unit #(
  parameter int MAX_SIDE = frfs_pkg::MAX_SIDE_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire [6:0]            cfg_data,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  frfs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output frfs_pkg::out_item_t  out_data
);
  import frfs_pkg::*;

  localparam int AW = $clog2(MAX_SIDE);
  localparam int DEPTH = 1 << (2 * AW);
  // signed coordinate width, wide enough for a row plus the signed amount
  localparam int CW = (AW + 2 > 9) ? AW + 2 : 9;

  // memories
  logic [23:0] frame_mem [DEPTH];
  logic [23:0] scratch_mem [DEPTH];

  // configuration
  logic [6:0] frame_side;
  always_ff @(posedge clk) begin
    if (rst) frame_side <= 7'd64;
    else if (cfg_we) frame_side <= cfg_data;
  end

  // side in use, clamped to 1..MAX_SIDE
  logic [AW:0] side;
  always_comb begin
    if (frame_side == 7'd0) side = (AW+1)'(1);
    else if (32'(frame_side) > MAX_SIDE) side = (AW+1)'(MAX_SIDE);
    else side = (AW+1)'(frame_side);
  end

  state_t state, state_next;
  op_t op;
  logic signed [7:0] amt;
  logic [1:0] rot;
  logic [AW-1:0] r, c;        // scan counters
  logic [AW-1:0] rq, cq;      // scan position of the read in flight
  logic [23:0] wpix;
  logic wpix_hit;
  logic hit;
  logic fill_white;
  logic last;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);

  // does this command remap the frame
  function automatic logic needs_pass(input in_item_t it);
    logic signed [7:0] a;
    a = it.amount;
    case (op_t'(it.operation))
      OP_SHUP, OP_SHLEFT: return a != 8'sd0;
      OP_ROT:             return (a > 8'sd0) && (a[1:0] != 2'd0);
      OP_FLIPR, OP_FLIPC: return a[0];
      default:            return 1'b0;
    endcase
  endfunction

  assign last = (32'(r) == 32'(side) - 1) && (32'(c) == 32'(side) - 1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_acc) begin
        if (op_t'(in_data.operation) == OP_READ) state_next = ST_READ;
        else if (needs_pass(in_data)) state_next = ST_COPY;
        else state_next = ST_DONE;
      end
      ST_READ: state_next = ST_DONE;
      ST_COPY: if (last) state_next = ST_BACK;
      ST_BACK: if (last) state_next = ST_DONE;
      ST_DONE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // source coordinate for the remap
  logic signed [CW-1:0] sr, sc, sn, snm, sa, srr, scc;
  always_comb begin
    sn = CW'(side);
    snm = sn - CW'(1);
    sa = CW'(amt);
    srr = CW'(r);
    scc = CW'(c);
    sr = srr;
    sc = scc;
    case (op)
      OP_SHUP:   sr = srr + sa;
      OP_SHLEFT: sc = scc + sa;
      OP_ROT: begin
        case (rot)
          2'd1: begin sr = snm - scc; sc = srr; end
          2'd2: begin sr = snm - srr; sc = snm - scc; end
          default: begin sr = scc; sc = snm - srr; end
        endcase
      end
      OP_FLIPR: sr = snm - srr;
      OP_FLIPC: sc = snm - scc;
      default: ;
    endcase
  end

  logic src_out;
  assign src_out = (sr < 0) || (sr >= sn) || (sc < 0) || (sc >= sn);

  // counters and command registers
  logic [AW-1:0] r_next, c_next;
  always_comb begin
    r_next = r;
    c_next = c;
    if (32'(c) == 32'(side) - 1) begin
      c_next = '0;
      r_next = last ? '0 : r + 1'b1;
    end else begin
      c_next = c + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r <= '0;
      c <= '0;
    end else if (state == ST_COPY || state == ST_BACK) begin
      r <= r_next;
      c <= c_next;
    end else begin
      r <= '0;
      c <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op <= op_t'(in_data.operation);
      amt <= in_data.amount;
      rot <= in_data.amount[1:0];
    end
    rq <= r;
    cq <= c;
  end

  // frame memory port
  logic [23:0] frame_rd, scratch_rd;
  logic in_frame;
  assign in_frame = (32'(in_data.pixel_row) < 32'(side))
                    && (32'(in_data.pixel_col) < 32'(side));

  logic fwe;
  logic [2*AW-1:0] fwa, fra, swa;
  always_comb begin
    fwe = 1'b0;
    fwa = {r, c};
    fra = {AW'(sr), AW'(sc)};
    if (state == ST_IDLE) begin
      fwe = in_acc && op_t'(in_data.operation) == OP_WRITE && in_frame;
      fwa = {AW'(in_data.pixel_row), AW'(in_data.pixel_col)};
      fra = {AW'(in_data.pixel_row), AW'(in_data.pixel_col)};
    end else if (state == ST_BACK) begin
      fwe = 1'b1;
      fwa = {rq, cq};
    end
    swa = {rq, cq};
  end

  // copy-back: scratch read of (r,c) lands next cycle, written at (rq,cq);
  // the final element is written in ST_DONE's first cycle via back_wr
  logic copy_wr, back_wr;
  logic tail_we;
  assign tail_we = back_wr && state != ST_BACK;

  always_ff @(posedge clk) begin
    if (fwe) frame_mem[fwa] <= (state == ST_IDLE) ? in_data.pixel_in : scratch_rd;
    else if (tail_we) frame_mem[{rq, cq}] <= scratch_rd;
    frame_rd <= frame_mem[fra];
  end

  // copy pass: write scratch in the cycle after the frame read
  always_ff @(posedge clk) begin
    if (rst) begin
      copy_wr <= 1'b0;
      back_wr <= 1'b0;
    end else begin
      copy_wr <= state == ST_COPY;
      back_wr <= state == ST_BACK;
    end
    fill_white <= src_out;
    hit <= in_acc && op_t'(in_data.operation) == OP_READ && in_frame;
  end

  // a one-pixel frame reads back the entry written in the same cycle
  always_ff @(posedge clk) begin
    if (copy_wr) scratch_mem[swa] <= fill_white ? WHITE : frame_rd;
    if (copy_wr && swa == {r, c}) scratch_rd <= fill_white ? WHITE : frame_rd;
    else scratch_rd <= scratch_mem[{r, c}];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) wpix <= hit ? frame_rd : 24'd0;
    else if (state == ST_IDLE && in_acc) wpix <= 24'd0;
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_data.pixel_out <= wpix;
      out_data.read_valid <= (op == OP_READ) && (wpix_hit);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) wpix_hit <= hit;
    else if (state == ST_IDLE && in_acc) wpix_hit <= 1'b0;
  end

endmodule
`default_nettype wire

// ----- dv/tb_frame_rotate_flip_shift_unit.sv -----
// testbench for the frame rotate/flip/shift unit: directed and random commands,
// checked against a predictor of the frame store; depends on frfs_pkg and the rtl
`timescale 1ns / 100ps
module tb_frame_rotate_flip_shift_unit;
  import frfs_pkg::*;

  localparam int SIDE_MAX = MAX_SIDE_DEF;
  localparam int DEPTH = SIDE_MAX * SIDE_MAX;
  localparam int STALL_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_data = 7'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  // predictor state: pixel values, which entries hold written data, side register
  logic [23:0] frame_img [DEPTH];
  logic [23:0] remap_img [DEPTH];
  bit frame_known [DEPTH];
  bit remap_known [DEPTH];
  logic [6:0] side_reg = 7'd64;

  in_item_t cmd_queue [$];
  out_item_t result_queue [$];
  int n_issued = 0;
  int n_taken = 0;
  int n_results = 0;
  int n_reads = 0;
  int n_remaps = 0;
  int n_errors = 0;
  int idle_max = 10;
  int send_gap = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  frame_rotate_flip_shift_unit uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // side in use: zero acts as one, anything above the maximum as the maximum
  function automatic int side_now();
    if (side_reg == 7'd0) return 1;
    if (side_reg > SIDE_MAX) return SIDE_MAX;
    return int'(side_reg);
  endfunction

  // whole-frame move: every destination in the region takes its source pixel,
  // or white when the source lies outside the frame
  function automatic void remap_frame(op_t op, int amt);
    int n;
    int sr;
    int sc;
    n = side_now();
    n_remaps++;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        sr = r;
        sc = c;
        case (op)
          OP_SHUP: sr = r + amt;
          OP_SHLEFT: sc = c + amt;
          OP_ROT: begin
            if (amt == 1) begin
              sr = n - 1 - c; sc = r;
            end else if (amt == 2) begin
              sr = n - 1 - r; sc = n - 1 - c;
            end else begin
              sr = c; sc = n - 1 - r;
            end
          end
          OP_FLIPR: sr = n - 1 - r;
          default: sc = n - 1 - c;
        endcase
        if (sr < 0 || sr >= n || sc < 0 || sc >= n) begin
          remap_img[r * SIDE_MAX + c] = WHITE;
          remap_known[r * SIDE_MAX + c] = 1'b1;
        end else begin
          remap_img[r * SIDE_MAX + c] = frame_img[sr * SIDE_MAX + sc];
          remap_known[r * SIDE_MAX + c] = frame_known[sr * SIDE_MAX + sc];
        end
      end
    end
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        frame_img[r * SIDE_MAX + c] = remap_img[r * SIDE_MAX + c];
        frame_known[r * SIDE_MAX + c] = remap_known[r * SIDE_MAX + c];
      end
    end
  endfunction

  // applies one command to the predicted frame and gives the expected result
  function automatic out_item_t frame_command(in_item_t t);
    out_item_t res;
    int n;
    int amt;
    int addr;
    res = '0;
    n = side_now();
    amt = int'($signed(t.amount));
    addr = int'(t.pixel_row) * SIDE_MAX + int'(t.pixel_col);
    case (op_t'(t.operation))
      OP_WRITE: begin
        if (t.pixel_row < n && t.pixel_col < n) begin
          frame_img[addr] = t.pixel_in;
          frame_known[addr] = 1'b1;
        end
      end
      OP_READ: begin
        if (t.pixel_row < n && t.pixel_col < n) begin
          res.pixel_out = frame_img[addr];
          res.read_valid = 1'b1;
          n_reads++;
        end
      end
      OP_SHUP, OP_SHLEFT: if (amt != 0) remap_frame(op_t'(t.operation), amt);
      OP_ROT: if (amt > 0 && amt % 4 != 0) remap_frame(OP_ROT, amt % 4);
      OP_FLIPR, OP_FLIPC: if (amt % 2 != 0) remap_frame(op_t'(t.operation), 0);
      default: ;
    endcase
    return res;
  endfunction

  // driver: a transaction is taken at an edge with valid high and stall low
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        result_queue.push_back(frame_command(in_data));
        n_taken++;
      end
      // a stalled transaction stays on the bus untouched
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= cmd_queue.pop_front();
          send_gap = $urandom_range(0, idle_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result transaction with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (result_queue.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result: pixel_out %h read_valid %b",
                     out_data.pixel_out, out_data.read_valid);
        end else begin
          want = result_queue.pop_front();
          if (out_data.pixel_out !== want.pixel_out
              || out_data.read_valid !== want.read_valid) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch at result %0d: pixel_out %h/%h read_valid %b/%b",
                       n_results, want.pixel_out, out_data.pixel_out,
                       want.read_valid, out_data.read_valid);
          end
        end
        stall_left = $urandom_range(0, idle_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // hands one command to the driver and waits until it has been taken,
  // so that the next one can be drawn against the predicted frame
  task automatic issue(op_t op, int row, int col, logic [23:0] pix, int amt);
    in_item_t t;
    t.operation = op;
    t.pixel_row = row[5:0];
    t.pixel_col = col[5:0];
    t.pixel_in = pix;
    t.amount = amt[7:0];
    cmd_queue.push_back(t);
    n_issued++;
    while (n_taken != n_issued) @(negedge clk);
  endtask

  // register write only once every result is back and the unit has settled
  task automatic set_side(logic [6:0] v);
    while (n_taken != n_issued || result_queue.size() != 0) @(negedge clk);
    repeat (12) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    side_reg = v;
  endtask

  task automatic random_command(int big);
    int n;
    int pick;
    int row;
    int col;
    int amt;
    bit found;
    n = side_now();
    pick = $urandom_range(0, 99);
    amt = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
                                       : int'($urandom_range(0, 2 * n + 2)) - (n + 1);
    if (pick < 40) begin
      // writes mostly land inside the frame, some fall outside and are dropped
      row = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
      col = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
      issue(OP_WRITE, row, col, 24'($urandom), amt);
    end else if (pick < 70) begin
      found = 1'b0;
      row = $urandom_range(0, 63);
      col = $urandom_range(0, 63);
      if (row < n && col < n) begin
        for (int k = 0; k < 30 && !found; k++) begin
          row = $urandom_range(0, n - 1);
          col = $urandom_range(0, n - 1);
          found = frame_known[row * SIDE_MAX + col];
        end
        if (!found) begin
          row = $urandom_range(0, n - 1);
          col = $urandom_range(0, n - 1);
          issue(OP_WRITE, row, col, 24'($urandom), amt);
          return;
        end
      end
      issue(OP_READ, row, col, 24'($urandom), amt);
    end else if (pick < 95) begin
      // whole-frame commands are costly on a big frame, so keep them rare there
      if (big && $urandom_range(0, 3) != 0)
        issue(OP_WRITE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
              24'($urandom), amt);
      else
        issue(op_t'($urandom_range(OP_SHUP, OP_FLIPC)), $urandom_range(0, 63),
              $urandom_range(0, 63), 24'($urandom), amt);
    end else begin
      issue(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63), 24'($urandom), amt);
    end
  endtask

  initial begin
    logic [6:0] sides [8];
    logic [23:0] probe;
    sides = '{7'd0, 7'd5, 7'd127, 7'd2, 7'd9, 7'd1, 7'd64, 7'd3};
    for (int i = 0; i < DEPTH; i++) begin
      frame_img[i] = '0;
      frame_known[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset side of 64: corners, every command, the odd amounts
    probe = 24'($urandom);
    issue(OP_WRITE, 0, 0, 24'h000000, 0);
    issue(OP_WRITE, 63, 63, 24'hFFFFFF, 0);
    issue(OP_WRITE, 0, 63, 24'h5AA5C3, 0);
    issue(OP_WRITE, 63, 0, 24'hA55A3C, 0);
    issue(OP_READ, 0, 63, 24'h0, 0);
    issue(OP_READ, 63, 63, 24'h0, 0);
    issue(OP_NONE, 63, 63, 24'hFFFFFF, -1);
    issue(OP_SHUP, 0, 0, 24'h0, 0);            // zero shift leaves the frame alone
    issue(OP_ROT, 0, 0, 24'h0, -1);            // negative turn count is ignored
    issue(OP_ROT, 0, 0, 24'h0, 4);             // full turn is ignored
    issue(OP_ROT, 0, 0, 24'h0, 1);
    issue(OP_READ, 0, 0, 24'h0, 0);
    issue(OP_ROT, 0, 0, 24'h0, 127);           // three quarter turns
    issue(OP_FLIPR, 0, 0, 24'h0, 2);           // even flip count is ignored
    issue(OP_FLIPR, 0, 0, 24'h0, -1);
    issue(OP_FLIPC, 0, 0, 24'h0, 1);
    issue(OP_READ, 63, 0, 24'h0, 0);
    issue(OP_SHUP, 0, 0, 24'h0, 64);           // shift by the whole side whitens all
    issue(OP_WRITE, 10, 20, probe, 0);
    issue(OP_SHLEFT, 0, 0, 24'h0, -3);
    issue(OP_READ, 10, 23, 24'h0, 0);
    issue(OP_SHUP, 0, 0, 24'h0, 5);
    issue(OP_READ, 5, 23, 24'h0, 0);
    issue(OP_SHLEFT, 0, 0, 24'h0, -128);
    issue(OP_READ, 63, 63, 24'h0, 0);

    // random phases over several sides, extremes included; idling is off in every third phase
    foreach (sides[p]) begin
      set_side(sides[p]);
      idle_max = (p % 3 == 1) ? 0 : 10;
      for (int k = 0; k < 10; k++) random_command(side_now() > 16);
    end

    while (n_taken != n_issued || result_queue.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    $display("%0d commands over %0d side settings: %0d results, %0d pixel reads, %0d remaps",
             n_issued, 1 + $size(sides), n_results, n_reads, n_remaps);
    if (n_errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/frfs_pkg.sv
rtl/frame_rotate_flip_shift_unit.sv
dv/tb_frame_rotate_flip_shift_unit.sv
